// File: rtl/uvst_pkg.sv
// uvst_pkg: shared types and codes for the unique value set table
// request and status codes, fsm state type and the cell control struct
// no dependencies
package uvst_pkg;

    // fixed payload widths of the request and result channels
    localparam int REQ_W    = 3;
    localparam int DATA_W   = 32;
    localparam int STATUS_W = 3;
    localparam int IDX_W    = 6;
    localparam int COUNT_W  = 7;

    // request kinds
    localparam logic [REQ_W-1:0] REQ_ADD    = 3'd0;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd1;
    localparam logic [REQ_W-1:0] REQ_SEARCH = 3'd2;
    localparam logic [REQ_W-1:0] REQ_FIRST  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_NEXT   = 3'd4;

    // result status codes
    localparam logic [STATUS_W-1:0] STS_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] STS_DUP      = 3'd1;
    localparam logic [STATUS_W-1:0] STS_NOTFOUND = 3'd2;
    localparam logic [STATUS_W-1:0] STS_END      = 3'd3;
    localparam logic [STATUS_W-1:0] STS_FULL     = 3'd4;
    localparam logic [STATUS_W-1:0] STS_EMPTY    = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    // per-cell control from the sequencer
    typedef struct packed {
        logic shift_en;   // take the neighbor's value (one scan step)
        logic take_head;  // tail cell: take the recirculated head instead
        logic load_en;    // append: take the request key
    } cell_ctrl_t;

endpackage

// File: rtl/uvst_req_if.sv
// uvst_req_if: request channel (valid, ready, request kind and value)
// depends on uvst_pkg for the payload widths
interface uvst_req_if;

    logic                           valid;
    logic                           ready;
    logic [uvst_pkg::REQ_W-1:0]     req_type;
    logic [uvst_pkg::DATA_W-1:0]    value_in;

    modport source (output valid, output req_type, output value_in, input ready);
    modport sink   (input valid, input req_type, input value_in, output ready);

endinterface

// File: rtl/uvst_rsp_if.sv
// uvst_rsp_if: result channel (valid, ready and the result fields)
// depends on uvst_pkg for the payload widths
interface uvst_rsp_if;

    logic                           valid;
    logic                           ready;
    logic [uvst_pkg::STATUS_W-1:0]  status;
    logic [uvst_pkg::IDX_W-1:0]     found_index;
    logic [uvst_pkg::DATA_W-1:0]    value_out;
    logic [uvst_pkg::COUNT_W-1:0]   entry_count;
    logic                           is_empty;

    modport source (
        output valid, output status, output found_index, output value_out,
        output entry_count, output is_empty, input ready
    );
    modport sink (
        input valid, input status, input found_index, input value_out,
        input entry_count, input is_empty, output ready
    );

endinterface

// File: rtl/uvst_cell.sv
// uvst_cell: one storage cell of the table chain
// holds one entry, shifts from its neighbor, takes the head or the key
// depends on uvst_pkg for the cell control struct
module uvst_cell #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                    clk,
    input  uvst_pkg::cell_ctrl_t    ctrl,
    input  logic [VALUE_WIDTH-1:0]  nbr_data,
    input  logic [VALUE_WIDTH-1:0]  head_data,
    input  logic [VALUE_WIDTH-1:0]  key,
    output logic [VALUE_WIDTH-1:0]  data
);

    logic [VALUE_WIDTH-1:0] data_reg;
    logic [VALUE_WIDTH-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (ctrl.load_en)
        begin
            data_next = key;
        end
        else if (ctrl.shift_en)
        begin
            data_next = ctrl.take_head ? head_data : nbr_data;
        end
    end

    // payload only, no reset
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// File: rtl/unique_value_set_table.sv
// unique_value_set_table: insertion-ordered set of distinct values
// top level: sequencer, result register and a chain of uvst_cell
// depends on uvst_pkg, uvst_req_if, uvst_rsp_if and uvst_cell
//
// usage
//   req channel carries req_type (add, remove, search, first, next) and
//   value_in; rsp channel returns status, found_index, value_out,
//   entry_count and is_empty, one result per request, in request order
//   entries live in a chain of cells, entry k in cell k; add, remove,
//   search and next rotate the chain once through the head cell, one step
//   per cycle, comparing or capturing the head; remove drops the match on
//   the way, which closes the gap
//   flow: add, remove, search and next on a non-empty table go through
//   the scan state and then the done state, other requests go straight
//   to done, where the result is registered on commit; a new request is
//   taken only once the sequencer is back in idle, after the last one
//   has committed; req ready is high whenever the sequencer is idle,
//   also while a result waits in the output register
//   receiver stall: a finished request holds in its final state until the
//   output register is free; nothing is dropped
//   reset: count and cursor clear, no transfer pending; entry contents
//   stay undefined until written, no clearing pass is needed
module unique_value_set_table #(
    parameter int CAPACITY    = 64,
    parameter int VALUE_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    uvst_req_if.sink    req,
    uvst_rsp_if.source  rsp
);

    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_BITS = $clog2(CAPACITY);

    // sequencer state
    uvst_pkg::state_t               state_reg, state_next;
    logic [uvst_pkg::REQ_W-1:0]     op_reg, op_next;
    logic [VALUE_WIDTH-1:0]         key_reg, key_next;
    logic [IDX_BITS-1:0]            step_reg, step_next;
    logic [CNT_W-1:0]               len_reg, len_next;
    logic                           found_reg, found_next;
    logic [IDX_BITS-1:0]            midx_reg, midx_next;
    logic [VALUE_WIDTH-1:0]         cap_reg, cap_next;
    logic [CNT_W-1:0]               count_reg, count_next;
    logic [CNT_W-1:0]               cursor_reg, cursor_next;

    // output register
    logic                           rsp_valid_reg, rsp_valid_next;
    logic [uvst_pkg::STATUS_W-1:0]  status_reg, status_next;
    logic [uvst_pkg::IDX_W-1:0]     fidx_reg, fidx_next;
    logic [uvst_pkg::DATA_W-1:0]    vout_reg, vout_next;
    logic [uvst_pkg::COUNT_W-1:0]   ecount_reg, ecount_next;
    logic                           empty_reg, empty_next;

    // result fields as built in the final state
    logic [uvst_pkg::STATUS_W-1:0]  sts;
    logic [IDX_BITS-1:0]            oidx;
    logic [VALUE_WIDTH-1:0]         oval;

    logic [VALUE_WIDTH-1:0]         key_in;
    logic [VALUE_WIDTH-1:0]         cells_q [CAPACITY];
    logic [VALUE_WIDTH-1:0]         head;
    uvst_pkg::cell_ctrl_t           ctrl [CAPACITY];

    logic                           scanning;
    logic                           hit;
    logic                           drop;
    logic                           nxt_hit;
    logic                           step_last;
    logic                           commit;
    logic                           append;

    // key is value_in cut or zero-extended to the stored width
    assign key_in = VALUE_WIDTH'(req.value_in);
    assign head   = cells_q[0];

    assign scanning  = (state_reg == uvst_pkg::ST_SCAN);
    // first match at the head during a rotation; values are distinct
    assign hit       = scanning && !found_reg && (head == key_reg)
                       && (op_reg inside {uvst_pkg::REQ_ADD, uvst_pkg::REQ_REMOVE,
                                          uvst_pkg::REQ_SEARCH});
    // remove: the matching head is not recirculated
    assign drop      = hit && (op_reg == uvst_pkg::REQ_REMOVE);
    // next: capture the head when it is the entry at the cursor
    assign nxt_hit   = scanning && (op_reg == uvst_pkg::REQ_NEXT)
                       && (CNT_W'(step_reg) == cursor_reg);
    assign step_last = (CNT_W'(step_reg) + 1'b1 == count_reg);
    assign commit    = (state_reg == uvst_pkg::ST_DONE) && (!rsp_valid_reg || rsp.ready);

    assign req.ready = (state_reg == uvst_pkg::ST_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        key_next       = key_reg;
        step_next      = step_reg;
        len_next       = len_reg;
        found_next     = found_reg;
        midx_next      = midx_reg;
        cap_next       = cap_reg;
        count_next     = count_reg;
        cursor_next    = cursor_reg;
        rsp_valid_next = rsp_valid_reg && !rsp.ready;
        status_next    = status_reg;
        fidx_next      = fidx_reg;
        vout_next      = vout_reg;
        ecount_next    = ecount_reg;
        empty_next     = empty_reg;
        sts            = uvst_pkg::STS_OK;
        oidx           = '0;
        oval           = '0;
        append         = 1'b0;

        case (state_reg)
            uvst_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    op_next    = req.req_type;
                    key_next   = key_in;
                    step_next  = '0;
                    len_next   = count_reg;
                    found_next = 1'b0;
                    midx_next  = '0;
                    // a rotation is needed only for kinds that look at every entry
                    if ((count_reg != '0)
                        && (req.req_type inside {uvst_pkg::REQ_ADD, uvst_pkg::REQ_REMOVE,
                                                 uvst_pkg::REQ_SEARCH, uvst_pkg::REQ_NEXT}))
                    begin
                        state_next = uvst_pkg::ST_SCAN;
                    end
                    else
                    begin
                        state_next = uvst_pkg::ST_DONE;
                    end
                end
            end

            uvst_pkg::ST_SCAN:
            begin
                if (hit)
                begin
                    found_next = 1'b1;
                    midx_next  = step_reg;
                end
                if (drop)
                begin
                    len_next = len_reg - 1'b1;
                end
                if (nxt_hit)
                begin
                    cap_next = head;
                end
                if (step_last)
                begin
                    state_next = uvst_pkg::ST_DONE;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end

            uvst_pkg::ST_DONE:
            begin
                if (commit)
                begin
                    case (op_reg)
                        uvst_pkg::REQ_ADD:
                        begin
                            // duplicate check wins over the full check
                            if (found_reg)
                            begin
                                sts  = uvst_pkg::STS_DUP;
                                oidx = midx_reg;
                            end
                            else if (count_reg == CNT_W'(CAPACITY))
                            begin
                                sts = uvst_pkg::STS_FULL;
                            end
                            else
                            begin
                                append     = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        uvst_pkg::REQ_REMOVE:
                        begin
                            if (count_reg == '0)
                            begin
                                sts = uvst_pkg::STS_EMPTY;
                            end
                            else if (!found_reg)
                            begin
                                sts = uvst_pkg::STS_NOTFOUND;
                            end
                            else
                            begin
                                oidx       = midx_reg;
                                count_next = count_reg - 1'b1;
                            end
                        end
                        uvst_pkg::REQ_SEARCH:
                        begin
                            if (count_reg == '0)
                            begin
                                sts = uvst_pkg::STS_EMPTY;
                            end
                            else if (!found_reg)
                            begin
                                sts = uvst_pkg::STS_NOTFOUND;
                            end
                            else
                            begin
                                oidx = midx_reg;
                            end
                        end
                        uvst_pkg::REQ_FIRST:
                        begin
                            if (count_reg == '0)
                            begin
                                sts = uvst_pkg::STS_EMPTY;
                            end
                            else
                            begin
                                oval        = head;
                                cursor_next = CNT_W'(1);
                            end
                        end
                        uvst_pkg::REQ_NEXT:
                        begin
                            if (count_reg == '0)
                            begin
                                sts = uvst_pkg::STS_EMPTY;
                            end
                            else if (cursor_reg >= count_reg)
                            begin
                                // also covers a cursor left beyond count by a remove
                                sts = uvst_pkg::STS_END;
                            end
                            else
                            begin
                                oval        = cap_reg;
                                cursor_next = cursor_reg + 1'b1;
                            end
                        end
                        default:
                        begin
                            // unused request kinds: ok with zero data
                        end
                    endcase

                    rsp_valid_next = 1'b1;
                    status_next    = sts;
                    fidx_next      = uvst_pkg::IDX_W'(oidx);
                    vout_next      = uvst_pkg::DATA_W'(oval);
                    ecount_next    = uvst_pkg::COUNT_W'(count_next);
                    empty_next     = (count_next == '0);
                    state_next     = uvst_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = uvst_pkg::ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= uvst_pkg::ST_IDLE;
            count_reg     <= '0;
            cursor_reg    <= '0;
            rsp_valid_reg <= 1'b0;
            step_reg      <= '0;
            len_reg       <= '0;
            found_reg     <= 1'b0;
            op_reg        <= uvst_pkg::REQ_ADD;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cursor_reg    <= cursor_next;
            rsp_valid_reg <= rsp_valid_next;
            step_reg      <= step_next;
            len_reg       <= len_next;
            found_reg     <= found_next;
            op_reg        <= op_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        key_reg    <= key_next;
        midx_reg   <= midx_next;
        cap_reg    <= cap_next;
        status_reg <= status_next;
        fidx_reg   <= fidx_next;
        vout_reg   <= vout_next;
        ecount_reg <= ecount_next;
        empty_reg  <= empty_next;
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = status_reg;
    assign rsp.found_index = fidx_reg;
    assign rsp.value_out   = vout_reg;
    assign rsp.entry_count = ecount_reg;
    assign rsp.is_empty    = empty_reg;

    // cell chain: each step moves every entry one place toward the head,
    // the head goes back in at the tail of the live entries unless a remove drops it
    for (genvar gi = 0; gi < CAPACITY; gi++)
    begin : g_chain
        logic [VALUE_WIDTH-1:0] nbr;

        if (gi < CAPACITY - 1)
        begin : g_mid
            assign nbr = cells_q[gi + 1];
        end
        else
        begin : g_end
            assign nbr = head;
        end

        assign ctrl[gi].shift_en  = scanning;
        assign ctrl[gi].take_head = scanning && !drop && (len_reg == CNT_W'(gi + 1));
        assign ctrl[gi].load_en   = append && (count_reg == CNT_W'(gi));

        uvst_cell #(
            .VALUE_WIDTH (VALUE_WIDTH)
        ) u_cell (
            .clk       (clk),
            .ctrl      (ctrl[gi]),
            .nbr_data  (nbr),
            .head_data (head),
            .key       (key_reg),
            .data      (cells_q[gi])
        );
    end

`ifndef SYNTHESIS
    // entry count never goes past the table size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    // a result shows up only when the sequencer commits a request
    a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid_reg) |-> $past(state_reg == uvst_pkg::ST_DONE))
        else $error("result without a committed request");

    // a rotation drops at most one entry
    a_len_track: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == uvst_pkg::ST_SCAN)
            |-> ((len_reg == count_reg) || (len_reg + 1'b1 == count_reg)))
        else $error("rotation length out of step with count");

    // request taken only when idle, and it starts a rotation or finishes
    a_accept_path: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready)
            |=> ((state_reg == uvst_pkg::ST_SCAN) || (state_reg == uvst_pkg::ST_DONE)))
        else $error("accepted request did not start");
`endif

endmodule

// File: sim/testbench.sv
`timescale 1ns / 100ps
// testbench: self-checking bench for unique_value_set_table on the req/rsp channels
// depends on uvst_pkg, uvst_req_if, uvst_rsp_if and the unique_value_set_table rtl
module testbench;

    localparam int CLK_PERIOD    = 10;
    localparam int TABLE_DEPTH   = 64;
    localparam int POOL_SIZE     = 96;    // more values than slots, so fills reach full
    localparam int ITEM_TARGET   = 700;
    localparam int QUIET_TAIL    = 100;   // last requests run with no idling on either side
    localparam int TAIL_CYCLES   = 80;    // longer than the worst request latency
    localparam int STUCK_LIMIT   = 2000;  // cycles with no transfer before giving up
    localparam int REPORT_LIMIT  = 40;

    // reserved request kinds: the block answers them ok with zero data and leaves the table as it is
    localparam logic [uvst_pkg::REQ_W-1:0] REQ_RSVD_FIRST = 3'd5;
    localparam logic [uvst_pkg::REQ_W-1:0] REQ_RSVD_LAST  = 3'd7;

    typedef struct packed {
        logic [uvst_pkg::STATUS_W-1:0] status;
        logic [uvst_pkg::IDX_W-1:0]    found_index;
        logic [uvst_pkg::DATA_W-1:0]   value_out;
        logic [uvst_pkg::COUNT_W-1:0]  entry_count;
        logic                          is_empty;
    } set_result_t;

    typedef enum int {
        MODE_FILL,
        MODE_DRAIN,
        MODE_MIX,
        MODE_WALK
    } traffic_mode_t;

    // mirror of the table plus the queue of results still owed by the block
    class set_table_scoreboard;
        logic [uvst_pkg::DATA_W-1:0] slots [TABLE_DEPTH];
        int unsigned                 fill;
        int unsigned                 cursor;
        set_result_t                 awaited [$];
        int unsigned                 errors;

        function new();
            fill   = 0;
            cursor = 0;
            errors = 0;
        endfunction

        function int find_slot(logic [uvst_pkg::DATA_W-1:0] v);
            for (int i = 0; i < fill; i++)
            begin
                if (slots[i] == v)
                    return i;
            end
            return -1;
        endfunction

        // apply one accepted request to the mirror and queue its result
        function void note_request(logic [uvst_pkg::REQ_W-1:0] kind,
                                   logic [uvst_pkg::DATA_W-1:0] v);
            set_result_t r;
            int          pos;
            r        = '0;
            r.status = uvst_pkg::STS_OK;
            case (kind)
                uvst_pkg::REQ_ADD:
                begin
                    pos = find_slot(v);
                    if (pos >= 0)
                    begin
                        r.status      = uvst_pkg::STS_DUP;
                        r.found_index = uvst_pkg::IDX_W'(pos);
                    end
                    else if (fill >= TABLE_DEPTH)
                        r.status = uvst_pkg::STS_FULL;
                    else
                    begin
                        slots[fill] = v;
                        fill++;
                    end
                end
                uvst_pkg::REQ_REMOVE:
                begin
                    pos = find_slot(v);
                    if (fill == 0)
                        r.status = uvst_pkg::STS_EMPTY;
                    else if (pos < 0)
                        r.status = uvst_pkg::STS_NOTFOUND;
                    else
                    begin
                        r.found_index = uvst_pkg::IDX_W'(pos);
                        for (int i = pos; i + 1 < fill; i++)
                            slots[i] = slots[i + 1];
                        fill--;
                    end
                end
                uvst_pkg::REQ_SEARCH:
                begin
                    pos = find_slot(v);
                    if (fill == 0)
                        r.status = uvst_pkg::STS_EMPTY;
                    else if (pos < 0)
                        r.status = uvst_pkg::STS_NOTFOUND;
                    else
                        r.found_index = uvst_pkg::IDX_W'(pos);
                end
                uvst_pkg::REQ_FIRST:
                begin
                    if (fill == 0)
                        r.status = uvst_pkg::STS_EMPTY;
                    else
                    begin
                        r.value_out = slots[0];
                        cursor      = 1;
                    end
                end
                uvst_pkg::REQ_NEXT:
                begin
                    if (fill == 0)
                        r.status = uvst_pkg::STS_EMPTY;
                    else if (cursor >= fill)
                        r.status = uvst_pkg::STS_END;
                    else
                    begin
                        r.value_out = slots[cursor];
                        cursor++;
                    end
                end
                default:
                begin
                end
            endcase
            r.entry_count = uvst_pkg::COUNT_W'(fill);
            r.is_empty    = (fill == 0);
            awaited = {awaited, r};
        endfunction

        task report(string what);
            if (errors < REPORT_LIMIT)
                $display("uvst check failed at %0t: %s", $time, what);
            errors++;
        endtask

        task check_result(set_result_t got);
            set_result_t want;
            if (awaited.size() == 0)
            begin
                report("result transfer with nothing outstanding");
                return;
            end
            want = awaited.pop_front();
            if (got.status !== want.status)
                report($sformatf("status %0d, want %0d", got.status, want.status));
            if (got.found_index !== want.found_index)
                report($sformatf("found_index %0d, want %0d",
                                 got.found_index, want.found_index));
            if (got.value_out !== want.value_out)
                report($sformatf("value_out %h, want %h", got.value_out, want.value_out));
            if (got.entry_count !== want.entry_count)
                report($sformatf("entry_count %0d, want %0d",
                                 got.entry_count, want.entry_count));
            if (got.is_empty !== want.is_empty)
                report($sformatf("is_empty %b, want %b", got.is_empty, want.is_empty));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    uvst_req_if req ();
    uvst_rsp_if rsp ();

    unique_value_set_table #(
        .CAPACITY    (TABLE_DEPTH),
        .VALUE_WIDTH (uvst_pkg::DATA_W)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    set_table_scoreboard         sb;
    logic [uvst_pkg::DATA_W-1:0] value_pool [POOL_SIZE];
    int unsigned                 requests_sent = 0;   // ignored kinds are not counted
    bit                          sender_idle_on = 1'b1;
    bit                          receiver_idle_on = 1'b1;

    always #(CLK_PERIOD / 2) clk = ~clk;

    // value source: mostly the shared pool so that adds collide and fills
    // reach capacity; present_pct steers toward values already stored
    function automatic logic [uvst_pkg::DATA_W-1:0] pick_value(int unsigned present_pct);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (sb.fill > 0 && r < present_pct)
            return sb.slots[$urandom_range(0, sb.fill - 1)];
        r = $urandom_range(0, 99);
        if (r < 85)
            return value_pool[$urandom_range(0, POOL_SIZE - 1)];
        if (r < 93)
            return $urandom();
        return r[0] ? '1 : '0;
    endfunction

    // request mix per traffic mode
    function automatic logic [uvst_pkg::REQ_W-1:0] pick_kind(traffic_mode_t mode);
        int unsigned r;
        r = $urandom_range(0, 99);
        case (mode)
            MODE_FILL:
            begin
                if (r < 80) return uvst_pkg::REQ_ADD;
                if (r < 88) return uvst_pkg::REQ_SEARCH;
                if (r < 93) return uvst_pkg::REQ_REMOVE;
                if (r < 96) return uvst_pkg::REQ_FIRST;
                return uvst_pkg::REQ_NEXT;
            end
            MODE_DRAIN:
            begin
                if (r < 65) return uvst_pkg::REQ_REMOVE;
                if (r < 78) return uvst_pkg::REQ_SEARCH;
                if (r < 85) return uvst_pkg::REQ_ADD;
                if (r < 92) return uvst_pkg::REQ_NEXT;
                return uvst_pkg::REQ_FIRST;
            end
            MODE_MIX:
            begin
                if (r < 30) return uvst_pkg::REQ_ADD;
                if (r < 55) return uvst_pkg::REQ_REMOVE;
                if (r < 70) return uvst_pkg::REQ_SEARCH;
                if (r < 80) return uvst_pkg::REQ_FIRST;
                if (r < 95) return uvst_pkg::REQ_NEXT;
                // noise: reserved kinds, answered ok with the table untouched
                return uvst_pkg::REQ_W'(REQ_RSVD_FIRST
                       + $urandom_range(0, REQ_RSVD_LAST - REQ_RSVD_FIRST));
            end
            default:
            begin
                // walk: mostly next, with the odd edit under the cursor
                if (r < 6) return uvst_pkg::REQ_REMOVE;
                if (r < 10) return uvst_pkg::REQ_ADD;
                if (r < 14) return uvst_pkg::REQ_FIRST;
                return uvst_pkg::REQ_NEXT;
            end
        endcase
    endfunction

    // drive one request and hold it until the transfer; valid stays high
    // into the next request unless a gap is drawn
    task automatic send_request(logic [uvst_pkg::REQ_W-1:0] kind,
                                logic [uvst_pkg::DATA_W-1:0] v);
        if (sender_idle_on && $urandom_range(0, 3) == 0)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        req.valid    <= 1'b1;
        req.req_type <= kind;
        req.value_in <= v;
        do
            @(posedge clk);
        while (!req.ready);
        sb.note_request(kind, v);
        if (kind <= uvst_pkg::REQ_NEXT)
            requests_sent++;
    endtask

    // sender holds off until every outstanding result has come back
    task automatic hold_until_drained();
        req.valid <= 1'b0;
        @(posedge clk);
        while (sb.awaited.size() != 0)
            @(posedge clk);
    endtask

    // empty-table errors, extremes of the value, duplicate, not found,
    // iteration to the end, ignored kinds, cursor left past count by a remove
    task automatic run_directed();
        send_request(uvst_pkg::REQ_SEARCH, '0);
        send_request(uvst_pkg::REQ_REMOVE, '1);
        send_request(uvst_pkg::REQ_FIRST, '0);
        send_request(uvst_pkg::REQ_NEXT, '0);
        send_request(uvst_pkg::REQ_ADD, '0);
        send_request(uvst_pkg::REQ_ADD, '1);
        send_request(uvst_pkg::REQ_ADD, '0);
        send_request(uvst_pkg::REQ_ADD, 32'h5a5a_a5a5);
        send_request(uvst_pkg::REQ_SEARCH, '1);
        send_request(uvst_pkg::REQ_SEARCH, 32'h1234_5678);
        send_request(uvst_pkg::REQ_REMOVE, 32'h1234_5678);
        send_request(uvst_pkg::REQ_FIRST, '0);
        send_request(uvst_pkg::REQ_NEXT, '0);
        send_request(uvst_pkg::REQ_NEXT, '0);
        send_request(uvst_pkg::REQ_NEXT, '0);
        for (int k = REQ_RSVD_FIRST; k <= REQ_RSVD_LAST; k++)
            send_request(uvst_pkg::REQ_W'(k), '1);
        send_request(uvst_pkg::REQ_FIRST, '0);
        send_request(uvst_pkg::REQ_NEXT, '0);
        send_request(uvst_pkg::REQ_NEXT, '0);
        // cursor sits at 3, the remove shrinks the table under it
        send_request(uvst_pkg::REQ_REMOVE, '0);
        send_request(uvst_pkg::REQ_NEXT, '0);
        send_request(uvst_pkg::REQ_REMOVE, 32'h5a5a_a5a5);
        send_request(uvst_pkg::REQ_ADD, 32'h8000_0001);
    endtask

    task automatic run_episode(traffic_mode_t mode, int unsigned length);
        logic [uvst_pkg::REQ_W-1:0] kind;
        int unsigned                present_pct;
        case (mode)
            MODE_FILL:  present_pct = 10;
            MODE_DRAIN: present_pct = 75;
            default:    present_pct = 40;
        endcase
        if (mode == MODE_WALK)
            send_request(uvst_pkg::REQ_FIRST, pick_value(present_pct));
        for (int n = 0; n < length && requests_sent < ITEM_TARGET; n++)
        begin
            // no idling on either side in the tail of the run
            if (requests_sent + QUIET_TAIL >= ITEM_TARGET)
            begin
                sender_idle_on   = 1'b0;
                receiver_idle_on = 1'b0;
            end
            kind = pick_kind(mode);
            send_request(kind, pick_value(present_pct));
        end
    endtask

    // result side: check every transfer, draw stall bursts while receiver idling is on
    initial
    begin
        int unsigned stall_left;
        set_result_t got;
        stall_left = 0;
        rsp.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp.valid === 1'b1 && rsp.ready === 1'b1)
            begin
                got.status      = rsp.status;
                got.found_index = rsp.found_index;
                got.value_out   = rsp.value_out;
                got.entry_count = rsp.entry_count;
                got.is_empty    = rsp.is_empty;
                sb.check_result(got);
            end
            if (!rst_n)
                rsp.ready <= 1'b0;
            else if (stall_left > 0)
            begin
                stall_left--;
                rsp.ready <= 1'b0;
            end
            else if (receiver_idle_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 4) - 1;
                rsp.ready <= 1'b0;
            end
            else
                rsp.ready <= 1'b1;
        end
    end

    // watchdog: any transfer on either channel restarts the count
    initial
    begin
        int unsigned stuck;
        stuck = 0;
        while (stuck < STUCK_LIMIT)
        begin
            @(posedge clk);
            if ((req.valid === 1'b1 && req.ready === 1'b1) ||
                (rsp.valid === 1'b1 && rsp.ready === 1'b1))
                stuck = 0;
            else
                stuck++;
        end
        $display("unique_value_set_table: mismatch");
        $finish;
    end

    // main sequence
    initial
    begin
        traffic_mode_t mode;
        int unsigned   length;
        sb = new();
        for (int i = 0; i < POOL_SIZE; i++)
            value_pool[i] = {25'($urandom() >> 7), 7'(i)};   // low bits keep the pool distinct
        req.valid    <= 1'b0;
        req.req_type <= uvst_pkg::REQ_ADD;
        req.value_in <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        hold_until_drained();

        // first random stretch is add-heavy, aimed at filling the table up to full
        run_episode(MODE_FILL, 150);
        hold_until_drained();

        while (requests_sent < ITEM_TARGET)
        begin
            // idling on either side, off for some stretches and for the tail
            sender_idle_on   = (requests_sent + QUIET_TAIL < ITEM_TARGET) &&
                               ($urandom_range(0, 3) != 0);
            receiver_idle_on = (requests_sent + QUIET_TAIL < ITEM_TARGET) &&
                               ($urandom_range(0, 3) != 0);
            mode = traffic_mode_t'($urandom_range(MODE_FILL, MODE_WALK));
            if (mode == MODE_WALK)
                length = sb.fill + 4;
            else
                length = $urandom_range(40, 160);
            run_episode(mode, length);
            if (sender_idle_on && $urandom_range(0, 3) == 0)
                hold_until_drained();
        end

        req.valid <= 1'b0;
        @(posedge clk);
        while (sb.awaited.size() != 0)
            @(posedge clk);
        // catch any stray result after the last expected one
        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("unique_value_set_table: match");
        else
            $display("unique_value_set_table: mismatch");
        $finish;
    end

endmodule

// File: filelist.f
rtl/uvst_pkg.sv
rtl/uvst_req_if.sv
rtl/uvst_rsp_if.sv
rtl/uvst_cell.sv
rtl/unique_value_set_table.sv
sim/testbench.sv
